[rtl/mbd_pkg.sv]
// ----------------------------------------------------------------------------
// mbd_pkg: shared definitions for the 2x2 mipmap box downsampler
// Holds field widths, register indexes, reset values and pixel format codes.
// ----------------------------------------------------------------------------
package mbd_pkg;

    // Field and register widths.
    localparam int PIX_W      = 64;
    localparam int PAIR_W     = 2 * PIX_W;
    localparam int FMT_W      = 2;
    localparam int DW_W       = 7;
    localparam int DH_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Line store depth default and the largest frame height.
    localparam int DEF_MAX_WIDTH = 64;
    localparam int MAX_HEIGHT    = 4096;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT  = 2'd2;

    // Pixel layouts. The unused code is handled as four 16-bit channels.
    typedef enum logic [FMT_W-1:0] {
        FMT_RGBA16 = 2'd0,
        FMT_RGBA8  = 2'd1,
        FMT_GRAY16 = 2'd2
    } t_pixel_fmt;

    // Register reset values.
    localparam logic [FMT_W-1:0] RST_PIXEL_FORMAT = FMT_RGBA16;
    localparam logic [DW_W-1:0]  RST_DEST_WIDTH   = 7'd64;
    localparam logic [DH_W-1:0]  RST_DEST_HEIGHT  = 13'd64;

endpackage

[rtl/mbd_line_store.sv]
// ----------------------------------------------------------------------------
// mbd_line_store: line store for the upper row of source pairs
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mbd_line_store #(
    parameter int DEPTH = mbd_pkg::DEF_MAX_WIDTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [mbd_pkg::PAIR_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [mbd_pkg::PAIR_W-1:0] o_rd_data
);

    logic [mbd_pkg::PAIR_W-1:0] r_mem [DEPTH];
    logic [mbd_pkg::PAIR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/mbd_reduce.sv]
// ----------------------------------------------------------------------------
// mbd_reduce: per-channel 2x2 rounded box average
// Averages each column pair vertically, then the two results horizontally.
// ----------------------------------------------------------------------------
module mbd_reduce (
    input  logic [mbd_pkg::PIX_W-1:0] i_upper_left,
    input  logic [mbd_pkg::PIX_W-1:0] i_upper_right,
    input  logic [mbd_pkg::PIX_W-1:0] i_lower_left,
    input  logic [mbd_pkg::PIX_W-1:0] i_lower_right,
    input  logic [mbd_pkg::FMT_W-1:0] i_format,
    output logic [mbd_pkg::PIX_W-1:0] o_pixel
);

    function automatic logic [15:0] avg16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b} + 17'd1;
        return s[16:1];
    endfunction

    function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b} + 9'd1;
        return s[8:1];
    endfunction

    logic [15:0] q16 [4];
    logic [7:0]  q8  [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            q16[c] = avg16(avg16(i_upper_left[16*c +: 16], i_lower_left[16*c +: 16]),
                           avg16(i_upper_right[16*c +: 16], i_lower_right[16*c +: 16]));
            q8[c]  = avg8(avg8(i_upper_left[8*c +: 8], i_lower_left[8*c +: 8]),
                          avg8(i_upper_right[8*c +: 8], i_lower_right[8*c +: 8]));
        end
    end

    always_comb begin
        case (i_format)
            mbd_pkg::FMT_RGBA8: begin
                o_pixel = {32'd0, q8[3], q8[2], q8[1], q8[0]};
            end
            mbd_pkg::FMT_GRAY16: begin
                o_pixel = {48'd0, q16[0]};
            end
            default: begin
                // Four 16-bit channels, also used for the undefined code.
                o_pixel = {q16[3], q16[2], q16[1], q16[0]};
            end
        endcase
    end

endmodule

[rtl/mipmap_box_downsample_2x2_unit.sv]
// ----------------------------------------------------------------------------
// mipmap_box_downsample_2x2_unit: 2x2 box-filter mipmap reducer
// Upper-row pairs go to a line store; each lower-row pair meets its stored
// pair and yields one destination pixel with row and frame end marks.
// ----------------------------------------------------------------------------
// Throughput: one source pair per cycle while the output is not stalled, set by the single line store access.
// Path: an accepted lower-row pair is captured in the first stage while its
// upper pair is read into the line store read register; the reduced pixel is
// then captured in the result register, from which it is offered.
// Reset clears the counters, the row phase, the valid flags and the configuration
// registers to their defaults; the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module mipmap_box_downsample_2x2_unit #(
    parameter int MAX_WIDTH = mbd_pkg::DEF_MAX_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Source pairs.
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [mbd_pkg::PAIR_W-1:0]     i_s_tdata,  // left_pixel, right_pixel
    // Destination pixels.
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [mbd_pkg::PIX_W-1:0]      o_m_tdata,  // out_pixel
    output logic                           o_m_tlast,  // row_end
    output logic                           o_m_tuser   // frame_end
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Configuration registers.
    logic [mbd_pkg::FMT_W-1:0] r_fmt;
    logic [mbd_pkg::DW_W-1:0]  r_dest_w;
    logic [mbd_pkg::DH_W-1:0]  r_dest_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= mbd_pkg::RST_PIXEL_FORMAT;
            r_dest_w <= mbd_pkg::RST_DEST_WIDTH;
            r_dest_h <= mbd_pkg::RST_DEST_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mbd_pkg::CFG_PIXEL_FORMAT: r_fmt    <= i_cfg_data[mbd_pkg::FMT_W-1:0];
                mbd_pkg::CFG_DEST_WIDTH:   r_dest_w <= i_cfg_data[mbd_pkg::DW_W-1:0];
                mbd_pkg::CFG_DEST_HEIGHT:  r_dest_h <= i_cfg_data[mbd_pkg::DH_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size, limited to the supported range.
    logic [mbd_pkg::DW_W:0] eff_w;
    logic [mbd_pkg::DH_W:0] eff_h;

    always_comb begin
        eff_w = {1'b0, r_dest_w};
        if (eff_w == '0) begin
            eff_w = (mbd_pkg::DW_W+1)'(1);
        end
        if (32'(eff_w) > MAX_WIDTH) begin
            eff_w = (mbd_pkg::DW_W+1)'(MAX_WIDTH);
        end
        eff_h = {1'b0, r_dest_h};
        if (eff_h == '0) begin
            eff_h = (mbd_pkg::DH_W+1)'(1);
        end
        if (32'(eff_h) > mbd_pkg::MAX_HEIGHT) begin
            eff_h = (mbd_pkg::DH_W+1)'(mbd_pkg::MAX_HEIGHT);
        end
    end

    // Position counters.
    logic [mbd_pkg::DW_W-1:0] r_col;
    logic [mbd_pkg::DH_W-1:0] r_row;
    logic                     r_phase;

    logic [mbd_pkg::DW_W-1:0] n_col;
    logic [mbd_pkg::DH_W-1:0] n_row;
    logic                     n_phase;

    logic          last_col;
    logic          last_row;
    logic [31:0]   col_ext;
    logic [AW-1:0] addr;

    assign last_col = ({1'b0, r_col} + (mbd_pkg::DW_W+1)'(1)) >= eff_w;
    assign last_row = ({1'b0, r_row} + (mbd_pkg::DH_W+1)'(1)) >= eff_h;
    assign col_ext  = 32'(r_col);
    assign addr     = (col_ext < MAX_WIDTH) ? col_ext[AW-1:0] : AW'(MAX_WIDTH - 1);

    // Handshake: the result register frees the pipeline whenever it is empty
    // or its transaction completes this cycle.
    logic r_s1_valid;
    logic r_out_valid;
    logic out_free;
    logic acc;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || out_free;
    assign acc        = i_s_tvalid && o_s_tready;

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_phase = r_phase;
        if (acc) begin
            if (last_col) begin
                n_col   = '0;
                n_phase = !r_phase;
                if (r_phase) begin
                    n_row = last_row ? '0 : r_row + mbd_pkg::DH_W'(1);
                end
            end else begin
                n_col = r_col + mbd_pkg::DW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_phase <= n_phase;
        end
    end

    // Line store: written on the upper row, read on the lower row.
    logic [mbd_pkg::PAIR_W-1:0] upper_pair;

    mbd_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (acc && !r_phase),
        .i_wr_addr (addr),
        .i_wr_data (i_s_tdata),
        .i_rd_en   (acc && r_phase),
        .i_rd_addr (addr),
        .o_rd_data (upper_pair)
    );

    // First stage: lower pair and end marks, aligned with the store read.
    logic [mbd_pkg::PAIR_W-1:0] r_s1_lower;
    logic                       r_s1_row_end;
    logic                       r_s1_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= r_phase;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && r_phase) begin
            r_s1_lower     <= i_s_tdata;
            r_s1_row_end   <= last_col;
            r_s1_frame_end <= last_col && last_row;
        end
    end

    // Reduction and result register.
    logic [mbd_pkg::PIX_W-1:0] pixel;

    mbd_reduce u_reduce (
        .i_upper_left  (upper_pair[mbd_pkg::PIX_W-1:0]),
        .i_upper_right (upper_pair[mbd_pkg::PAIR_W-1:mbd_pkg::PIX_W]),
        .i_lower_left  (r_s1_lower[mbd_pkg::PIX_W-1:0]),
        .i_lower_right (r_s1_lower[mbd_pkg::PAIR_W-1:mbd_pkg::PIX_W]),
        .i_format      (r_fmt),
        .o_pixel       (pixel)
    );

    logic [mbd_pkg::PIX_W-1:0] r_out_pixel;
    logic                      r_out_row_end;
    logic                      r_out_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_pixel     <= pixel;
            r_out_row_end   <= r_s1_row_end;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pixel;
    assign o_m_tlast  = r_out_row_end;
    assign o_m_tuser  = r_out_frame_end;

    // The frame only ends on the last pixel of a row.
    a_frame_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_frame_end || r_out_row_end))
        else $error("frame end without row end");

    // An upper-row transaction never produces a pending result.
    a_upper_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !r_phase) |=> !r_s1_valid)
        else $error("upper-row pair produced a result");

    // The last pair of a lower row carries the row end mark into the pipeline.
    a_lower_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_phase && last_col) |=> (r_s1_valid && r_s1_row_end))
        else $error("lower-row end not marked");

    // The row counter moves only at the end of a lower row.
    a_row_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(acc && r_phase && last_col) |=> $stable(r_row))
        else $error("row counter moved mid-row");

endmodule
